// ===== src/b32e_pkg.sv =====
// b32e_pkg: shared types, constants and functions of the base32 stream encoder
// no dependencies; used by every module of the encoder
package b32e_pkg;

    localparam logic [7:0] PadChar    = 8'h3D;
    localparam int         QueueDepth = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_text;
    } t_out;

    // one byte's worth of output: symbol indexes, then padding
    typedef struct packed {
        logic [2:0][4:0] syms;
        logic [1:0]      nsym;
        logic [2:0]      npad;
        logic            last;
    } t_job;

    function automatic logic [7:0] symbol_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < 5'd26) begin
            ch = 8'h41 + {3'b000, idx};
        end else begin
            ch = 8'h32 + {3'b000, idx} - 8'd26;
        end
        return ch;
    endfunction

    // padding after the last byte, by bytes already taken in the group
    function automatic logic [2:0] pad_count(input logic [2:0] pos);
        logic [2:0] p;
        unique case (pos)
            3'd0:    p = 3'd6;
            3'd1:    p = 3'd4;
            3'd2:    p = 3'd3;
            3'd3:    p = 3'd1;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== src/b32e_front.sv =====
// b32e_front: accepts message bytes, keeps the residue and group position,
// and turns each byte into a job for the back end; uses b32e_pkg
module b32e_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  b32e_pkg::t_in  i_data,
    output b32e_pkg::t_job o_job
);

    logic [3:0] r_res_bits;
    logic [2:0] r_res_cnt;
    logic [2:0] r_grp_pos;
    logic [3:0] n_res_bits;
    logic [2:0] n_res_cnt;
    logic [2:0] n_grp_pos;

    always_comb begin
        logic [2:0]  cnt;
        logic [2:0]  pos;
        logic [11:0] acc;
        logic [3:0]  bits;
        logic [2:0]  rem;
        logic [11:0] masked;
        logic [4:0]  tail;
        cnt    = (r_res_cnt > 3'd4) ? 3'd4 : r_res_cnt;
        pos    = (r_grp_pos > 3'd4) ? 3'd4 : r_grp_pos;
        acc    = {r_res_bits, i_data.data_byte};
        bits   = {1'b0, cnt} + 4'd8;
        o_job  = '0;
        o_job.syms[0] = 5'(acc >> (bits - 4'd5));
        if (bits >= 4'd10) begin
            o_job.syms[1] = 5'(acc >> (bits - 4'd10));
            o_job.nsym    = 2'd2;
            rem           = 3'(bits - 4'd10);
        end else begin
            o_job.nsym    = 2'd1;
            rem           = 3'(bits - 4'd5);
        end
        masked = acc & ((12'd1 << rem) - 12'd1);
        tail   = 5'(masked << (3'd5 - rem));
        o_job.last = i_data.final_byte;
        n_res_bits = masked[3:0];
        n_res_cnt  = rem;
        n_grp_pos  = (pos == 3'd4) ? 3'd0 : pos + 3'd1;
        if (i_data.final_byte) begin
            if (rem != 3'd0) begin
                o_job.syms[o_job.nsym] = tail;
                o_job.nsym             = o_job.nsym + 2'd1;
            end
            o_job.npad = b32e_pkg::pad_count(pos);
            n_res_bits = '0;
            n_res_cnt  = '0;
            n_grp_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= '0;
            r_res_cnt  <= '0;
            r_grp_pos  <= '0;
        end else if (i_accept) begin
            r_res_bits <= n_res_bits;
            r_res_cnt  <= n_res_cnt;
            r_grp_pos  <= n_grp_pos;
        end
    end

endmodule

// ===== src/b32e_queue.sv =====
// b32e_queue: two-entry job queue between front and back end
// uses b32e_pkg for the job type and depth
module b32e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b32e_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b32e_pkg::t_job o_job
);

    localparam int AddrW = $clog2(b32e_pkg::QueueDepth);

    b32e_pkg::t_job r_mem [b32e_pkg::QueueDepth];
    logic [AddrW-1:0] r_wp;
    logic [AddrW-1:0] r_rp;
    logic [AddrW:0]   r_cnt;

    assign o_full  = (r_cnt == (AddrW + 1)'(b32e_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AddrW + 1)'(i_push) - (AddrW + 1)'(i_pop);
        end
    end

endmodule

// ===== src/b32e_back.sv =====
// b32e_back: sequencer that sends one character per cycle from each job while the receiver is ready
// uses b32e_pkg for the job and output types and the alphabet
module b32e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  b32e_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output b32e_pkg::t_out o_data
);

    b32e_pkg::t_job r_job;
    logic           r_busy;
    logic [2:0]     r_idx;
    logic [3:0]     total;
    logic           at_end;
    logic           done;

    assign total   = {2'b00, r_job.nsym} + {1'b0, r_job.npad};
    assign at_end  = ({1'b0, r_idx} == total - 4'd1);
    assign done    = r_busy && i_ready && at_end;
    assign o_q_pop = !i_q_empty && (!r_busy || done);
    assign o_valid = r_busy;

    always_comb begin
        if (r_idx < {1'b0, r_job.nsym}) begin
            o_data.out_char = b32e_pkg::symbol_char(r_job.syms[r_idx[1:0]]);
        end else begin
            o_data.out_char = b32e_pkg::PadChar;
        end
        o_data.end_of_text = r_job.last && at_end;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

// ===== src/base32_stream_encoder_top.sv =====
// base32_stream_encoder_top: base32 text encoder, one byte in, one character out
// instantiates b32e_front, b32e_queue and b32e_back; uses b32e_pkg
// Each byte becomes one or two characters (three with the tail symbol on the
// last byte) plus up to six '=' pads on the last byte; the back end sends one
// character per cycle while the receiver is ready. A byte is taken in the cycle
// it arrives while the two-entry job queue has room, and end_of_text marks the
// last character of each message.
module base32_stream_encoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  b32e_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output b32e_pkg::t_out o_out_data
);

    b32e_pkg::t_job front_job;
    b32e_pkg::t_job q_job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           in_accept;

    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && !q_full;

    b32e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_data   (i_in_data),
        .o_job    (front_job)
    );

    b32e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    b32e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule

// ===== src/b32e_checker.sv =====
// b32e_checker: port-level assertions for the base32 stream encoder
// bound to base32_stream_encoder_top; uses b32e_pkg
module b32e_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input b32e_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input b32e_pkg::t_out o_out_data
);

    logic [7:0] ch;
    assign ch = o_out_data.out_char;

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while stalled");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // only alphabet characters or padding leave the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h32 && ch <= 8'h37)
            || ch == b32e_pkg::PadChar)
        else $error("illegal output character");

    // reset leaves no output pending
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    // padding is never followed by a symbol in the same transaction stream
    a_pad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && ch == b32e_pkg::PadChar && !o_out_data.end_of_text
        |=> o_out_valid && o_out_data.out_char == b32e_pkg::PadChar)
        else $error("symbol after padding");

endmodule

bind base32_stream_encoder_top b32e_checker u_b32e_checker (.*);

// ===== test/base32_stream_encoder_top_test.sv =====
`timescale 1ns / 1ps
// base32_stream_encoder_top_test: self-checking testbench for the base32 stream encoder
// depends on b32e_pkg and base32_stream_encoder_top; predicts every character and compares
module base32_stream_encoder_top_test;

    localparam int CycleLimit = 250000;
    localparam int RandomBytes = 225;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    b32e_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    b32e_pkg::t_out o_out_data;

    base32_stream_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    string b32_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    int    chars_per_group[5] = '{2, 4, 5, 7, 8};

    // encoder state as predicted
    logic [3:0] leftover_bits = '0;
    logic [2:0] leftover_count = '0;
    logic [2:0] bytes_in_group = '0;

    b32e_pkg::t_out expected_chars[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   in_gaps_on = 1'b0;
    bit   out_stalls_on = 1'b0;

    task automatic encode_byte(input b32e_pkg::t_in item);
        logic [11:0]    acc;
        int             nbits;
        int             npad;
        int             pos;
        b32e_pkg::t_out ch;
        acc = {leftover_bits, item.data_byte};
        nbits = int'(leftover_count) + 8;
        pos = int'(bytes_in_group) + 1;
        while (nbits >= 5) begin
            nbits -= 5;
            expected_chars.push_back({b32_alphabet[int'((acc >> nbits) & 12'h1F)], 1'b0});
        end
        acc &= (12'd1 << nbits) - 12'd1;
        if (item.final_byte) begin
            if (nbits > 0) begin
                expected_chars.push_back({b32_alphabet[int'((acc << (5 - nbits)) & 12'h1F)],
                                          1'b0});
            end
            npad = 8 - chars_per_group[pos - 1];
            repeat (npad) expected_chars.push_back({b32e_pkg::PadChar, 1'b0});
            ch = expected_chars.pop_back();
            ch.end_of_text = 1'b1;
            expected_chars.push_back(ch);
            leftover_bits = '0;
            leftover_count = '0;
            bytes_in_group = '0;
        end else begin
            leftover_bits = acc[3:0];
            leftover_count = 3'(nbits);
            bytes_in_group = (pos >= 5) ? 3'd0 : 3'(pos);
        end
    endtask

    // predict on every input transaction, then check every output transaction
    always @(posedge i_clk) begin
        b32e_pkg::t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                encode_byte(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected output transaction, expected none, got %h/%b",
                             $time, o_out_data.out_char, o_out_data.end_of_text);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_out_data.out_char !== want.out_char) begin
                        $display("%0t: out_char expected %h got %h",
                                 $time, want.out_char, o_out_data.out_char);
                        error_count++;
                    end
                    if (o_out_data.end_of_text !== want.end_of_text) begin
                        $display("%0t: end_of_text expected %b got %b",
                                 $time, want.end_of_text, o_out_data.end_of_text);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout, %0d characters still expected",
                     $time, expected_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls in random bursts while out_stalls_on is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (out_stalls_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= {b, fin};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // messages of one to six bytes: every padding length, full group, group wrap
    task automatic test_group_lengths();
        logic [7:0] pattern[4];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01};
        send_byte(8'h00, 1'b1);
        for (int len = 1; len <= 6; len++) begin
            for (int i = 0; i < len; i++) begin
                send_byte(pattern[(len + i) % 4], i == len - 1);
            end
        end
    endtask

    task automatic test_idle_pause();
        wait_for_drain();
        send_message(3);
        wait_for_drain();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < RandomBytes) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            in_gaps_on = ($urandom_range(0, 3) != 0);
            out_stalls_on = ($urandom_range(0, 3) != 0);
            send_message(len);
            sent += len;
            if ($urandom_range(0, 7) == 0) begin
                wait_for_drain();
            end
        end
    endtask

    task automatic test_streaming();
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        for (int len = 1; len <= 7; len++) begin
            send_message(len);
        end
    endtask

    initial begin
        test_reset();
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        test_group_lengths();
        test_idle_pause();
        test_random_messages();
        test_streaming();
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
